/* rtl/core/cfp_pkg.sv */
// Package for the checksummed frame parser.
// Holds the register reset values, register indexes, parser phase type and
// the result and configuration structs. Depends on nothing.
`default_nettype none

package cfp_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 6;
	localparam int unsigned CfgIdxW = 3;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxW-1:0] REG_FIRST_HEADER   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SECOND_HEADER  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FUNCTION_LIMIT = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LENGTH_LIMIT   = 3'd3;

	// Register reset values.
	localparam logic [ByteW-1:0] FIRST_HEADER_RST   = 8'hAA;
	localparam logic [ByteW-1:0] SECOND_HEADER_RST  = 8'hAF;
	localparam logic [ByteW-1:0] FUNCTION_LIMIT_RST = 8'd240;
	localparam logic [LenW-1:0]  LENGTH_LIMIT_RST   = 6'd49;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_HDR2 = 3'd1,
		PH_FUNC = 3'd2,
		PH_LEN  = 3'd3,
		PH_DATA = 3'd4,
		PH_CSUM = 3'd5
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] first_header;
		logic [ByteW-1:0] second_header;
		logic [ByteW-1:0] function_limit;
		logic [LenW-1:0]  length_limit;
	} cfp_cfg_t;

	typedef struct packed {
		logic             result_kind;
		logic [ByteW-1:0] payload_byte;
		logic [ByteW-1:0] function_code;
		logic [LenW-1:0]  byte_index;
		logic [LenW-1:0]  payload_length;
		logic             checksum_good;
	} cfp_result_t;

endpackage

`default_nettype wire

/* rtl/core/cfp_ifs.sv */
// Handshake interfaces for the received byte channel and the result channel.
// Depends on cfp_pkg for the field widths.
`default_nettype none

interface cfp_byte_if;
	import cfp_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfp_result_if;
	import cfp_pkg::*;
	logic             valid;
	logic             ready;
	logic             result_kind;
	logic [ByteW-1:0] payload_byte;
	logic [ByteW-1:0] function_code;
	logic [LenW-1:0]  byte_index;
	logic [LenW-1:0]  payload_length;
	logic             checksum_good;
	modport source (output valid, output result_kind, output payload_byte,
		output function_code, output byte_index, output payload_length,
		output checksum_good, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input function_code, input byte_index, input payload_length,
		input checksum_good, output ready);
endinterface

`default_nettype wire

/* rtl/core/cfp_cfg_regs.sv */
// Configuration registers of the frame parser: headers and limits.
// Depends on cfp_pkg for the register indexes and reset values.
`default_nettype none

module cfp_cfg_regs (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [cfp_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [cfp_pkg::ByteW-1:0]   cfg_wdata,
	output cfp_pkg::cfp_cfg_t            cfg
);
	import cfp_pkg::*;

	cfp_cfg_t cfg_q;

	// Write decode; an index beyond the list changes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_header   <= FIRST_HEADER_RST;
			cfg_q.second_header  <= SECOND_HEADER_RST;
			cfg_q.function_limit <= FUNCTION_LIMIT_RST;
			cfg_q.length_limit   <= LENGTH_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_HEADER:   cfg_q.first_header   <= cfg_wdata;
				REG_SECOND_HEADER:  cfg_q.second_header  <= cfg_wdata;
				REG_FUNCTION_LIMIT: cfg_q.function_limit <= cfg_wdata;
				REG_LENGTH_LIMIT:   cfg_q.length_limit   <= cfg_wdata[LenW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/cfp_out_buf.sv */
// Result register with a skid stage, so the parser can take one more word while
// a finished result waits. Depends on cfp_pkg for the result struct.
`default_nettype none

module cfp_out_buf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire cfp_pkg::cfp_result_t up_data,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output cfp_pkg::cfp_result_t      dn_data
);
	import cfp_pkg::*;

	logic        out_v_q;
	logic        skid_v_q;
	cfp_result_t out_q;
	cfp_result_t skid_q;

	assign up_ready = !skid_v_q;
	assign dn_valid = out_v_q;
	assign dn_data  = out_q;

	// Valid flags of the result register and the skid stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (up_valid && up_ready) begin
			if (out_v_q && !dn_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (dn_ready) begin
			out_v_q  <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	// Payload registers follow the same decisions and need no reset.
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			if (out_v_q && !dn_ready) begin
				skid_q <= up_data;
			end else begin
				out_q <= up_data;
			end
		end else if (dn_ready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	// The skid stage only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid stage full with result register empty");

	// A held result with a skid entry keeps both until the receiver takes one.
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !dn_ready |=> skid_v_q && out_v_q)
		else $error("skid entry lost while stalled");

	// A fresh word behind a stalled result lands in the skid stage.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && up_ready && out_v_q && !dn_ready |=> skid_v_q && skid_q == $past(up_data))
		else $error("stalled word not captured in skid stage");

endmodule

`default_nettype wire

/* rtl/core/cfp_parser.sv */
// Frame parser state machine: header hunt, limits, payload counting and the
// running checksum. Depends on cfp_pkg for the phase type and structs.
`default_nettype none

module cfp_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfp_pkg::cfp_cfg_t     cfg,
	input  wire logic                  acc,
	input  wire logic [cfp_pkg::ByteW-1:0] rx_byte,
	output logic                       res_valid,
	output cfp_pkg::cfp_result_t       res
);
	import cfp_pkg::*;

	phase_t           phase_q, phase_d;
	logic [LenW-1:0]  bytes_left_q, bytes_left_d;
	logic [ByteW-1:0] sum_q, sum_d;
	logic [ByteW-1:0] func_q, func_d;
	logic [LenW-1:0]  len_q, len_d;
	logic [LenW-1:0]  pos_q, pos_d;
	logic [LenW-1:0]  left_dec;

	assign left_dec = bytes_left_q - LenW'(1);

	// Next state and frame bookkeeping for one accepted word.
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		sum_d        = sum_q;
		func_d       = func_q;
		len_d        = len_q;
		pos_d        = pos_q;
		case (phase_q)
			PH_HDR2: begin
				if (rx_byte == cfg.second_header) begin
					sum_d   = sum_q + rx_byte;
					phase_d = PH_FUNC;
				end
			end
			PH_FUNC: begin
				if (rx_byte <= cfg.function_limit) begin
					sum_d   = sum_q + rx_byte;
					func_d  = rx_byte;
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (rx_byte <= {2'b00, cfg.length_limit}) begin
					sum_d        = sum_q + rx_byte;
					len_d        = rx_byte[LenW-1:0];
					bytes_left_d = rx_byte[LenW-1:0];
					pos_d        = '0;
					phase_d      = (rx_byte[LenW-1:0] == '0) ? PH_CSUM : PH_DATA;
				end
			end
			PH_DATA: begin
				sum_d        = sum_q + rx_byte;
				pos_d        = pos_q + LenW'(1);
				bytes_left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_CSUM;
				end
			end
			PH_CSUM: begin
				phase_d = PH_HUNT;
			end
			default: begin
				// Hunting, and any unused code behaves as hunting.
				if (rx_byte == cfg.first_header) begin
					sum_d   = rx_byte;
					phase_d = PH_HDR2;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	// Result word for payload and checksum bytes.
	always_comb begin
		res.result_kind    = KIND_PAYLOAD;
		res.payload_byte   = rx_byte;
		res.function_code  = func_q;
		res.byte_index     = pos_q;
		res.payload_length = len_q;
		res.checksum_good  = 1'b0;
		res_valid          = 1'b0;
		case (phase_q)
			PH_DATA: begin
				res_valid = acc;
			end
			PH_CSUM: begin
				res_valid         = acc;
				res.result_kind   = KIND_END;
				res.payload_byte  = '0;
				res.byte_index    = '0;
				res.checksum_good = (rx_byte == sum_q);
			end
			default: ;
		endcase
	end

	// Parser state, updated only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= '0;
			sum_q        <= '0;
			func_q       <= '0;
			len_q        <= '0;
			pos_q        <= '0;
		end else if (acc) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			sum_q        <= sum_d;
			func_q       <= func_d;
			len_q        <= len_d;
			pos_q        <= pos_d;
		end
	end

	// The payload phase always has at least one byte still to come.
	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bytes_left_q != '0)
		else $error("payload phase with no bytes left");

	// The last payload byte leads to the checksum byte.
	a_last_to_csum: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_DATA && bytes_left_q == LenW'(1) |=> phase_q == PH_CSUM)
		else $error("last payload byte did not reach checksum phase");

	// After the checksum byte the parser hunts again.
	a_csum_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_CSUM |=> phase_q == PH_HUNT)
		else $error("checksum byte did not end the frame");

	// Index plus bytes left always equals the declared length in the payload.
	a_index_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> LenW'(pos_q + bytes_left_q) == len_q)
		else $error("payload index out of step with length");

endmodule

`default_nettype wire

/* rtl/core/checksummed_frame_parser_unit.sv */
// Top level of the checksummed frame parser.
// Uses cfp_pkg, the interfaces in cfp_ifs, cfp_cfg_regs, cfp_parser and cfp_out_buf.
//
// rx carries one received byte per word. A frame is two header bytes, a
// function byte, a length byte, that many payload bytes and a checksum byte
// equal to the 8-bit sum of all earlier frame bytes. Bytes that do not fit a
// header, function or length slot are dropped and the parser waits there.
// res carries one word per payload byte (with its function code, index and
// the declared length) and one end-of-frame word per checksum byte with a
// good/bad flag. Header, function and length bytes give no word.
// The configuration port writes the two header values and the two limits by
// index; write it only while no frame traffic is in flight.
// One byte is taken every cycle while rx.ready is high, and its result reaches res
// through a result register with one skid entry.
// If the receiver stalls, bytes that give no word are still taken; the next
// byte that gives a word fills the skid entry and rx.ready then stays low
// until res takes the waiting word.
// arst_n clears the parser to header hunting, empties the result path and
// restores the registers to 0xAA, 0xAF, 240 and 49.
`default_nettype none

module checksummed_frame_parser_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	cfp_byte_if.sink                         rx,
	cfp_result_if.source                     res,
	input  wire logic                        cfg_we,
	input  wire logic [cfp_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [cfp_pkg::ByteW-1:0]   cfg_wdata
);
	import cfp_pkg::*;

	cfp_cfg_t    cfg;
	cfp_result_t par_res;
	cfp_result_t out_res;
	logic        par_valid;
	logic        buf_ready;
	logic        acc;

	assign rx.ready = buf_ready;
	assign acc      = rx.valid && buf_ready;

	cfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.acc       (acc),
		.rx_byte   (rx.rx_byte),
		.res_valid (par_valid),
		.res       (par_res)
	);

	cfp_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (par_valid),
		.up_ready (buf_ready),
		.up_data  (par_res),
		.dn_valid (res.valid),
		.dn_ready (res.ready),
		.dn_data  (out_res)
	);

	// Unpack the result word onto the channel.
	assign res.result_kind    = out_res.result_kind;
	assign res.payload_byte   = out_res.payload_byte;
	assign res.function_code  = out_res.function_code;
	assign res.byte_index     = out_res.byte_index;
	assign res.payload_length = out_res.payload_length;
	assign res.checksum_good  = out_res.checksum_good;

endmodule

`default_nettype wire

/* sim/tb_checksummed_frame_parser_unit.sv */
// Testbench for checksummed_frame_parser_unit: drives received bytes, checks every result word
// against a cycle-free parser model held here, and walks the registers through several settings.
// Depends on cfp_pkg and the interfaces in cfp_ifs, both from the RTL tree.
`default_nettype none

module tb_checksummed_frame_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cfp_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_STALL    = 300;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [ByteW-1:0]     cfg_wdata;

	cfp_byte_if   rx_ch ();
	cfp_result_if res_ch ();

	checksummed_frame_parser_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Parser model state and its own copy of the registers.
	cfp_cfg_t          regs;
	phase_t            prs_phase;
	logic [LenW-1:0]   prs_remaining;
	logic [ByteW-1:0]  prs_sum;
	logic [ByteW-1:0]  prs_function;
	logic [LenW-1:0]   prs_length;
	logic [LenW-1:0]   prs_index;

	cfp_result_t parsed_words[$];
	int          mismatch_count = 0;
	int          bytes_sent = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          stall_request = 0;

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string msg);
		$display("%0t: MISMATCH %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
		end
	endtask

	// Advances the parser model by one accepted byte and queues any word it gives.
	function automatic void parse_byte(input logic [ByteW-1:0] b);
		cfp_result_t w;
		case (prs_phase)
			PH_HDR2: begin
				if (b == regs.second_header) begin
					prs_sum += b;
					prs_phase = PH_FUNC;
				end
			end
			PH_FUNC: begin
				if (b <= regs.function_limit) begin
					prs_sum += b;
					prs_function = b;
					prs_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				if (b <= {2'b00, regs.length_limit}) begin
					prs_sum += b;
					prs_length = b[LenW-1:0];
					prs_remaining = b[LenW-1:0];
					prs_index = '0;
					// A zero length skips the payload altogether.
					prs_phase = (b[LenW-1:0] == '0) ? PH_CSUM : PH_DATA;
				end
			end
			PH_DATA: begin
				prs_sum += b;
				w = '{result_kind: KIND_PAYLOAD, payload_byte: b, function_code: prs_function,
					byte_index: prs_index, payload_length: prs_length, checksum_good: 1'b0};
				parsed_words.push_back(w);
				prs_index++;
				prs_remaining--;
				if (prs_remaining == '0) begin
					prs_phase = PH_CSUM;
				end
			end
			PH_CSUM: begin
				w = '{result_kind: KIND_END, payload_byte: '0, function_code: prs_function,
					byte_index: '0, payload_length: prs_length,
					checksum_good: (b == prs_sum)};
				parsed_words.push_back(w);
				prs_phase = PH_HUNT;
			end
			default: begin
				if (b == regs.first_header) begin
					prs_sum = b;
					prs_phase = PH_HDR2;
				end else begin
					prs_phase = PH_HUNT;
				end
			end
		endcase
	endfunction

	// Offers one byte, with an occasional idle burst first, and waits for the edge that takes it.
	task automatic send_byte(input logic [ByteW-1:0] b);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk iff rx_ch.ready);
		parse_byte(b);
		bytes_sent++;
	endtask

	// Stops offering and waits until every expected word has come, then lets the block settle.
	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		while (parsed_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FIRST_HEADER:   regs.first_header = val;
			REG_SECOND_HEADER:  regs.second_header = val;
			REG_FUNCTION_LIMIT: regs.function_limit = val;
			REG_LENGTH_LIMIT:   regs.length_limit = val[LenW-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [ByteW-1:0] h1, input logic [ByteW-1:0] h2,
			input logic [ByteW-1:0] flim, input logic [ByteW-1:0] llim);
		write_reg(REG_FIRST_HEADER, h1);
		write_reg(REG_SECOND_HEADER, h2);
		write_reg(REG_FUNCTION_LIMIT, flim);
		write_reg(REG_LENGTH_LIMIT, llim);
	endtask

	// Sends one frame under the current registers. A broken frame carries stray bytes in
	// the header, function and length slots and may be cut short.
	task automatic send_frame(input logic [ByteW-1:0] fn, input logic [LenW-1:0] len,
			input bit broken);
		logic [ByteW-1:0] fb[$];
		logic [ByteW-1:0] sum;
		logic [ByteW-1:0] d;
		int cut;
		fb = {regs.first_header, regs.second_header, fn, {2'b00, len}};
		sum = regs.first_header + regs.second_header + fn + {2'b00, len};
		for (int i = 0; i < len; i++) begin
			d = 8'($urandom);
			sum += d;
			fb.push_back(d);
		end
		// About one checksum in five is spoiled.
		if ($urandom_range(0, 4) == 0) begin
			sum ^= 8'($urandom_range(1, 255));
		end
		fb.push_back(sum);
		if (broken && $urandom_range(0, 1) == 1) begin
			cut = $urandom_range(1, fb.size() - 1);
		end else begin
			cut = fb.size();
		end
		for (int k = 0; k < cut; k++) begin
			if (broken && $urandom_range(0, 1) == 1) begin
				if (k == 1) begin
					send_byte(regs.second_header + 8'($urandom_range(1, 255)));
				end else if (k == 2 && regs.function_limit != 8'hFF) begin
					send_byte(8'($urandom_range(int'(regs.function_limit) + 1, 255)));
				end else if (k == 3) begin
					send_byte(8'($urandom_range(int'(regs.length_limit) + 1, 255)));
				end
			end
			send_byte(fb[k]);
		end
	endtask

	task automatic send_random_frame(input bit broken);
		logic [ByteW-1:0] fn;
		logic [LenW-1:0]  len;
		int short_max;
		fn = 8'($urandom_range(0, regs.function_limit));
		short_max = (regs.length_limit < 8) ? regs.length_limit : 8;
		// Mostly short payloads, now and then anything up to the limit.
		if ($urandom_range(0, 15) == 0) begin
			len = LenW'($urandom_range(0, regs.length_limit));
		end else begin
			len = LenW'($urandom_range(0, short_max));
		end
		send_frame(fn, len, broken);
	endtask

	// Feeds bytes that lead the parser back to header hunting after a cut frame.
	task automatic resync_to_hunt();
		while (prs_phase != PH_HUNT) begin
			case (prs_phase)
				PH_HDR2: send_byte(regs.second_header);
				PH_FUNC: send_byte(8'($urandom_range(0, regs.function_limit)));
				PH_LEN:  send_byte(8'($urandom_range(0, regs.length_limit)));
				default: send_byte(8'($urandom));
			endcase
		end
	endtask

	task automatic send_random_traffic(input int n_items);
		int stop_at;
		int pick;
		stop_at = bytes_sent + n_items;
		while (bytes_sent < stop_at) begin
			resync_to_hunt();
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_random_frame(1'b0);
			end else if (pick == 7) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end else begin
				send_random_frame(1'b1);
			end
		end
	endtask

	// Zero length, noise before a header, a wrong second header, function and length bytes
	// over their limits, extreme byte values, good and bad checksums.
	task automatic test_directed_frames();
		logic [ByteW-1:0] seq[$];
		seq = {FIRST_HEADER_RST, SECOND_HEADER_RST, 8'h00, 8'h00, 8'h59,
			8'h55, FIRST_HEADER_RST, 8'h12, FIRST_HEADER_RST, SECOND_HEADER_RST,
			8'hF1, 8'hF0, 8'h32, 8'h01, 8'hFF, 8'h00,
			FIRST_HEADER_RST, SECOND_HEADER_RST, 8'h05, 8'h02, 8'h00, 8'hFF, 8'h5F};
		foreach (seq[i]) send_byte(seq[i]);
		wait_idle();
	endtask

	// Registers changed while a frame is part way through its header.
	task automatic test_mid_frame_writes();
		send_byte(regs.first_header);
		wait_idle();
		write_reg(REG_SECOND_HEADER, 8'h3C);
		send_byte(SECOND_HEADER_RST);
		send_byte(8'h3C);
		wait_idle();
		write_reg(REG_FUNCTION_LIMIT, 8'h10);
		send_byte(8'h20);
		send_byte(8'h10);
		wait_idle();
		write_reg(REG_LENGTH_LIMIT, 8'h02);
		send_byte(8'h03);
		send_byte(8'h02);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(prs_sum);
		wait_idle();
		write_all(FIRST_HEADER_RST, SECOND_HEADER_RST, FUNCTION_LIMIT_RST,
			{2'b00, LENGTH_LIMIT_RST});
	endtask

	// Extreme settings: zero limits, all-ones limits (the length limit masked to six bits), equal headers.
	task automatic test_register_extremes();
		write_all(8'h00, 8'hFF, 8'h00, 8'h00);
		send_frame(8'h00, 6'd0, 1'b0);
		repeat (4) send_random_frame(1'b1);
		resync_to_hunt();
		wait_idle();
		write_all(8'hFF, 8'h00, 8'hFF, 8'hFF);
		send_frame(8'hFF, 6'd63, 1'b0);
		repeat (4) send_random_frame(1'b1);
		resync_to_hunt();
		wait_idle();
		write_all(8'h5A, 8'h5A, 8'($urandom), 8'($urandom));
		repeat (6) send_random_frame(1'b0);
		resync_to_hunt();
		wait_idle();
	endtask

	// Writes to indexes past the last register must leave the settings alone.
	task automatic test_unused_indexes();
		write_all(FIRST_HEADER_RST, SECOND_HEADER_RST, FUNCTION_LIMIT_RST,
			{2'b00, LENGTH_LIMIT_RST});
		for (int i = int'(REG_LENGTH_LIMIT) + 1; i < (1 << CfgIdxW); i++) begin
			write_reg(CfgIdxW'(i), 8'($urandom));
		end
		repeat (4) send_random_frame(1'b0);
		wait_idle();
	endtask

	// The receiver holds off for a long stretch while frames keep coming, so the input stalls.
	task automatic test_receiver_stall();
		stall_request = LONG_STALL;
		repeat (4) send_frame(8'($urandom_range(0, regs.function_limit)), 6'd8, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		for (int chunk = 0; chunk < 5; chunk++) begin
			wait_idle();
			write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			// One chunk runs with no idling on either side.
			tx_idle_on = (chunk != 2);
			rx_idle_on = (chunk != 2);
			send_random_traffic(200);
		end
		wait_idle();
	endtask

	task automatic test_quiet_tail();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_all(FIRST_HEADER_RST, SECOND_HEADER_RST, FUNCTION_LIMIT_RST,
			{2'b00, LENGTH_LIMIT_RST});
		send_random_traffic(200);
		resync_to_hunt();
		wait_idle();
	endtask

	// Receiver side: random idle bursts, plus a long hold-off when one is asked for.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall_request) @(posedge clk);
				stall_request = 0;
				res_ch.ready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Each word taken on the result channel is checked against the oldest expected one.
	always @(posedge clk) begin : res_monitor
		cfp_result_t got;
		cfp_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{result_kind: res_ch.result_kind, payload_byte: res_ch.payload_byte,
				function_code: res_ch.function_code, byte_index: res_ch.byte_index,
				payload_length: res_ch.payload_length, checksum_good: res_ch.checksum_good};
			if (parsed_words.size() == 0) begin
				report_mismatch($sformatf("word 0x%0h with no byte behind it", got));
			end else begin
				want = parsed_words.pop_front();
				check_field("result_kind", got.result_kind, want.result_kind);
				check_field("payload_byte", got.payload_byte, want.payload_byte);
				check_field("function_code", got.function_code, want.function_code);
				check_field("byte_index", got.byte_index, want.byte_index);
				check_field("payload_length", got.payload_length, want.payload_length);
				check_field("checksum_good", got.checksum_good, want.checksum_good);
			end
		end
	end

	// Watchdog.
	initial begin
		#(4_000_000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		regs = '{first_header: FIRST_HEADER_RST, second_header: SECOND_HEADER_RST,
			function_limit: FUNCTION_LIMIT_RST, length_limit: LENGTH_LIMIT_RST};
		prs_phase = PH_HUNT;
		prs_remaining = '0;
		prs_sum = '0;
		prs_function = '0;
		prs_length = '0;
		prs_index = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_mid_frame_writes();
		test_register_extremes();
		test_unused_indexes();
		test_receiver_stall();
		test_random_traffic();
		test_quiet_tail();

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
